@@ rtl/trh_pkg.sv @@
// ----------------------------------------------------------------------------
// trh_pkg
// shared types and constants of the letter trigram histogram
// ----------------------------------------------------------------------------
package trh_pkg;

  localparam int unsigned LETTER_BASE       = 96;
  localparam int unsigned LETTER_W          = 5;
  localparam int unsigned ADDR_W            = 3 * LETTER_W;
  localparam int unsigned STORE_DEPTH       = 1 << ADDR_W;
  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned COUNT_WIDTH_DEF   = 32;
  localparam int unsigned ALPHABET_SIZE_DEF = 27;
  localparam int unsigned ACTION_W          = 2;
  localparam int unsigned CHAR_W            = 8;
  localparam int unsigned IN_TDATA_W        = 32;
  localparam int unsigned OUT_TDATA_W       = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FEED = 2'd0,
    ACT_END  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_BUMP   = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2
  } op_kind_e;

  typedef enum logic {
    RES_COUNT = 1'b0,
    RES_READ  = 1'b1
  } res_kind_e;

  typedef struct packed {
    op_kind_e             kind;
    logic [ADDR_W-1:0]    addr;
    logic [VALUE_W-1:0]   count;
  } op_t;

  typedef struct packed {
    res_kind_e            kind;
    logic [VALUE_W-1:0]   value;
  } res_t;

endpackage

@@ rtl/trh_front.sv @@
// ----------------------------------------------------------------------------
// trh_front
// decodes input words, keeps the letter history and word length, forms ops
// ----------------------------------------------------------------------------
module trh_front import trh_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [LETTER_W-1:0] read_letter_i,
  input  logic [LETTER_W-1:0] read_prev_one_i,
  input  logic [LETTER_W-1:0] read_prev_two_i,
  input  logic                in_ready_i,
  output logic                op_valid_o,
  output op_t                 op_o
);

  logic [LETTER_W-1:0] prev_q, prev_d;
  logic [LETTER_W-1:0] prev2_q, prev2_d;
  logic [VALUE_W-1:0]  count_q, count_d;
  logic [CHAR_W-1:0]   code;
  logic                is_letter;
  logic                accept;

  assign accept    = in_valid_i && in_ready_i;
  assign code      = char_code_i - CHAR_W'(LETTER_BASE);
  assign is_letter = (char_code_i > CHAR_W'(LETTER_BASE)) &&
                     (code < CHAR_W'(ALPHABET_SIZE));

  always_comb begin
    op_valid_o = 1'b0;
    op_o.kind  = OP_BUMP;
    op_o.addr  = {code[LETTER_W-1:0], prev_q, prev2_q};
    op_o.count = count_q;
    prev_d     = prev_q;
    prev2_d    = prev2_q;
    count_d    = count_q;
    case (action_e'(action_i))
      ACT_FEED: begin
        if (is_letter) begin
          op_valid_o = in_valid_i;
          prev_d     = code[LETTER_W-1:0];
          prev2_d    = prev_q;
          if (count_q != '1) count_d = count_q + 1'b1;
        end
      end
      ACT_END: begin
        op_valid_o = in_valid_i;
        op_o.kind  = OP_FINISH;
        op_o.addr  = {LETTER_W'(0), prev_q, prev2_q};
        prev_d     = '0;
        prev2_d    = '0;
        count_d    = '0;
      end
      ACT_READ: begin
        op_valid_o = in_valid_i;
        op_o.kind  = OP_READ;
        op_o.addr  = {read_letter_i, read_prev_one_i, read_prev_two_i};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      prev2_q <= '0;
      count_q <= '0;
    end else if (accept) begin
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/trh_store.sv @@
// ----------------------------------------------------------------------------
// trh_store
// counter memory with clearing pass, read-modify-write stage and forwarding
// ----------------------------------------------------------------------------
module trh_store import trh_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_valid_i,
  input  op_t  op_i,
  output logic in_ready_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_ready_i
);

  logic [COUNT_WIDTH-1:0] mem [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_q;

  logic                   clr_q;
  logic [ADDR_W-1:0]      clr_addr_q;

  logic                   s1_valid_q;
  op_t                    s1_op_q;

  logic                   lw_valid_q;
  logic [ADDR_W-1:0]      lw_addr_q;
  logic [COUNT_WIDTH-1:0] lw_data_q;

  logic                   re;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] bumped;
  logic                   has_res;
  logic                   advance;
  logic                   bump_we;
  logic                   wide;

  // newest value of the entry: the write just before this read is not yet seen
  assign cur     = (lw_valid_q && lw_addr_q == s1_op_q.addr) ? lw_data_q : rdata_q;
  assign bumped  = (cur == '1) ? cur : cur + 1'b1;
  assign has_res = (s1_op_q.kind != OP_BUMP);
  assign advance = s1_valid_q && (!has_res || res_ready_i);
  assign bump_we = advance && (s1_op_q.kind != OP_READ);

  assign in_ready_o = !clr_q && (!s1_valid_q || advance);
  assign re         = op_valid_i && in_ready_o;
  assign we         = clr_q || bump_we;
  assign waddr      = clr_q ? clr_addr_q : s1_op_q.addr;
  assign wdata      = clr_q ? '0 : bumped;

  assign wide        = |(cur >> VALUE_W);
  assign res_valid_o = s1_valid_q && has_res;

  always_comb begin
    if (s1_op_q.kind == OP_READ) begin
      res_o.kind  = RES_READ;
      res_o.value = wide ? '1 : VALUE_W'(cur);
    end else begin
      res_o.kind  = RES_COUNT;
      res_o.value = s1_op_q.count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[op_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (re) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (clr_q) begin
        lw_valid_q <= 1'b0;
      end else if (bump_we) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) s1_op_q <= op_i;
    if (bump_we) begin
      lw_addr_q <= s1_op_q.addr;
      lw_data_q <= bumped;
    end
  end

endmodule

@@ rtl/letter_trigram_histogram.sv @@
// ----------------------------------------------------------------------------
// letter_trigram_histogram
// counts letter trigrams of a character stream in a memory of counters
// ----------------------------------------------------------------------------
//
//  channel   dir  width  content
//  s_axis    in   32     tdata: action[1:0] char_code[9:2] read_letter[14:10]
//                        read_prev_one[19:15] read_prev_two[24:20]
//  m_axis    out  32+1   tdata: result_value[31:0]  tuser: result_kind
//
//  one word per cycle sustained; a word's counter is read at the accepting
//  edge into the store stage and bumped and written back as it advances; a
//  bump on the entry just written takes that value from a bypass register
//  after reset a clearing pass zeroes all 32768 counters, one per cycle,
//  and s_axis_tready stays low until it is done; a full output register
//  under an m_axis stall holds up a result word and every word behind it
//
module letter_trigram_histogram import trh_pkg::*; #(
  parameter int unsigned COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // action, char_code, read_letter, read_prev_one, read_prev_two, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_value
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic                   m_axis_tuser
);

  logic   op_valid;
  op_t    op;
  logic   res_valid;
  res_t   res;
  logic   res_ready;
  logic   out_valid_q;
  res_t   out_q;

  // history and word length live here; they advance only on words the store accepts
  trh_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .action_i       (s_axis_tdata[1:0]),
    .char_code_i    (s_axis_tdata[9:2]),
    .read_letter_i  (s_axis_tdata[14:10]),
    .read_prev_one_i(s_axis_tdata[19:15]),
    .read_prev_two_i(s_axis_tdata[24:20]),
    .in_ready_i     (s_axis_tready),
    .op_valid_o     (op_valid),
    .op_o           (op)
  );

  // counter memory, read-modify-write with bypass
  trh_store #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .in_ready_o (s_axis_tready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  // output register: takes a new word whenever it is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.kind;

endmodule

@@ dv/letter_trigram_histogram_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_trigram_histogram_test
// self-checking bench: streams characters, word ends and counter reads into
// the histogram, predicts every result word from its own copy of the counter
// store and compares them in order under several idle and stall mixes
// ----------------------------------------------------------------------------
module letter_trigram_histogram_test;
  import trh_pkg::*;

  localparam int unsigned RESET_CYCLES   = 11;
  // must outlast the clearing pass, during which nothing moves, plus any stalls
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned PHASE_ITEMS    = 405;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned HOT_DEPTH      = 64;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // action, char_code, read_letter, read_prev_one, read_prev_two, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // result_value
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // result_kind
  logic                   m_axis_tuser;

  // predicted histogram state
  logic [VALUE_W-1:0]  tally_model [STORE_DEPTH];
  logic [LETTER_W-1:0] last_letter    = '0;
  logic [LETTER_W-1:0] older_letter   = '0;
  logic [VALUE_W-1:0]  letters_so_far = '0;
  res_t                pending_results [$];
  // recently bumped entries, so reads mostly hit live counters
  logic [ADDR_W-1:0]   hot_entries [$];

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned counted_items  = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  letter_trigram_histogram uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic bit is_counted_letter(logic [CHAR_W-1:0] ch);
    return (ch > LETTER_BASE) && ((ch - LETTER_BASE) < ALPHABET_SIZE_DEF);
  endfunction

  function automatic void bump_tally(logic [ADDR_W-1:0] idx);
    if (tally_model[idx] != '1) begin
      tally_model[idx] = tally_model[idx] + 1'b1;
    end
    hot_entries = {hot_entries, idx};
    if (hot_entries.size() > HOT_DEPTH) begin
      void'(hot_entries.pop_front());
    end
  endfunction

  function automatic void log_mismatch(string msg);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("%s", msg);
    end
    mismatch_count++;
  endfunction

  // one accepted input word -> state update and at most one expected result
  function automatic void predict_histogram(logic [IN_TDATA_W-1:0] w);
    action_e             act;
    logic [CHAR_W-1:0]   ch;
    logic [CHAR_W-1:0]   offset;
    logic [LETTER_W-1:0] code;
    res_t                res;
    act = action_e'(w[1:0]);
    ch  = w[9:2];
    case (act)
      ACT_FEED: begin
        if (is_counted_letter(ch)) begin
          offset = ch - CHAR_W'(LETTER_BASE);
          code   = offset[LETTER_W-1:0];
          bump_tally({code, last_letter, older_letter});
          older_letter = last_letter;
          last_letter  = code;
          if (letters_so_far != '1) begin
            letters_so_far = letters_so_far + 1'b1;
          end
        end
      end
      ACT_END: begin
        bump_tally({{LETTER_W{1'b0}}, last_letter, older_letter});
        res.kind  = RES_COUNT;
        res.value = letters_so_far;
        pending_results = {pending_results, res};
        last_letter    = '0;
        older_letter   = '0;
        letters_so_far = '0;
      end
      ACT_READ: begin
        res.kind  = RES_READ;
        res.value = tally_model[{w[14:10], w[19:15], w[24:20]}];
        pending_results = {pending_results, res};
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_result(logic kind, logic [OUT_TDATA_W-1:0] w);
    res_t               want;
    logic               got_kind;
    logic [VALUE_W-1:0] got_value;
    got_kind  = kind;
    got_value = w[VALUE_W-1:0];
    if (pending_results.size() == 0) begin
      log_mismatch($sformatf("unexpected result: kind %0d value %0d",
                             got_kind, got_value));
    end else begin
      want = pending_results.pop_front();
      if (got_kind !== want.kind || got_value !== want.value) begin
        log_mismatch($sformatf(
          "result mismatch: expected kind %0d value %0d, got kind %0d value %0d",
          want.kind, want.value, got_kind, got_value));
      end
    end
  endfunction

  // check, predict and watchdog, all on values from before the edge
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      check_result(m_axis_tuser, m_axis_tdata);
    end
    if (s_axis_tvalid && s_axis_tready === 1'b1) begin
      predict_histogram(s_axis_tdata);
    end
    if ((m_axis_tvalid === 1'b1 && m_axis_tready) ||
        (s_axis_tvalid && s_axis_tready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic push_word(action_e act, logic [CHAR_W-1:0] ch, logic [LETTER_W-1:0] rl,
                           logic [LETTER_W-1:0] p1, logic [LETTER_W-1:0] p2);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, p2, p1, rl, ch, act};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    @(negedge clk_i);
    if (!(act == ACT_NONE || (act == ACT_FEED && !is_counted_letter(ch)))) begin
      counted_items++;
    end
  endtask

  task automatic send_feed(logic [CHAR_W-1:0] ch);
    push_word(ACT_FEED, ch, LETTER_W'($urandom), LETTER_W'($urandom),
              LETTER_W'($urandom));
  endtask

  task automatic send_end();
    push_word(ACT_END, CHAR_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
              LETTER_W'($urandom));
  endtask

  task automatic send_read(logic [LETTER_W-1:0] rl, logic [LETTER_W-1:0] p1,
                           logic [LETTER_W-1:0] p2);
    push_word(ACT_READ, CHAR_W'($urandom), rl, p1, p2);
  endtask

  // sender holds off until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_directed_cases();
    int unsigned i;
    send_idle_pct = 0;
    stall_pct     = 0;
    // repeated letter: last two bumps hit the same counter back to back
    for (i = 0; i < 4; i++) send_feed(8'd97);
    send_end();
    send_read(5'd1, 5'd0, 5'd0);
    send_read(5'd1, 5'd1, 5'd1);
    send_read(5'd0, 5'd1, 5'd1);
    // top letter plus non-letter bytes on both sides of the range
    send_feed(8'd122);
    send_feed(8'd96);
    send_feed(8'd123);
    send_feed(8'd0);
    send_feed(8'd255);
    send_feed(8'd121);
    send_end();
    send_read(5'd25, 5'd26, 5'd0);
    send_read(5'd0, 5'd25, 5'd26);
    // empty word bumps the all-zero entry
    send_end();
    send_read(5'd0, 5'd0, 5'd0);
    // unused action does nothing
    push_word(ACT_NONE, 8'hff, 5'h1f, 5'h1f, 5'h1f);
    // codes past the alphabet read straight from the store
    send_read(5'd31, 5'd31, 5'd31);
    send_read(5'd27, 5'd30, 5'd28);
    send_read(5'd26, 5'd26, 5'd26);
    drain_results();
  endtask

  // mostly well-formed words with random letters, mixed with reads and noise
  task automatic test_word_traffic(int unsigned send_pct, int unsigned stall);
    int unsigned        stop_at;
    int unsigned        roll;
    int unsigned        len;
    int unsigned        i;
    bit                 narrow;
    logic [ADDR_W-1:0]  idx;
    send_idle_pct = send_pct;
    stall_pct     = stall;
    stop_at       = counted_items + PHASE_ITEMS;
    while (counted_items < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        len    = $urandom_range(9);
        narrow = ($urandom_range(3) == 0);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0) begin
            send_feed(CHAR_W'($urandom));
          end else if (narrow) begin
            send_feed(8'd97 + CHAR_W'($urandom_range(2)));
          end else begin
            send_feed(8'd97 + CHAR_W'($urandom_range(25)));
          end
        end
        // an occasional missing end lets words run together
        if ($urandom_range(9) != 0) send_end();
      end else if (roll < 93) begin
        if (hot_entries.size() != 0 && $urandom_range(2) != 0) begin
          idx = hot_entries[$urandom_range(hot_entries.size() - 1)];
          send_read(idx[14:10], idx[9:5], idx[4:0]);
        end else begin
          send_read(LETTER_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom));
        end
      end else if (roll < 97) begin
        push_word(ACT_NONE, CHAR_W'($urandom), LETTER_W'($urandom),
                  LETTER_W'($urandom), LETTER_W'($urandom));
      end else begin
        send_feed(CHAR_W'($urandom));
      end
    end
    drain_results();
  endtask

  initial begin
    foreach (tally_model[k]) tally_model[k] = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_word_traffic(0, 0);
    test_word_traffic(50, 0);
    test_word_traffic(0, 50);
    test_word_traffic(19, 19);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/trh_pkg.sv
rtl/trh_front.sv
rtl/trh_store.sv
rtl/letter_trigram_histogram.sv
dv/letter_trigram_histogram_test.sv
